// ===== src/tpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfd_pkg
// Shared types and constants of the touchpad packet framer and decoder.
// ----------------------------------------------------------------------------
package tpfd_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned SHIFT_W  = 40;
  localparam int unsigned PACKET_W = 48;
  localparam int unsigned COORD_W  = 13;

  // framing checks on bytes 0 and 3
  localparam logic [BYTE_W-1:0] HDR_MASK     = 8'hC8;
  localparam logic [BYTE_W-1:0] FIRST_MATCH  = 8'h80;
  localparam logic [BYTE_W-1:0] FOURTH_MATCH = 8'hC0;

  // byte positions inside a packet
  localparam logic [POS_W-1:0] POS_FIRST  = 3'd0;
  localparam logic [POS_W-1:0] POS_SECOND = 3'd1;
  localparam logic [POS_W-1:0] POS_THIRD  = 3'd2;
  localparam logic [POS_W-1:0] POS_FOURTH = 3'd3;
  localparam logic [POS_W-1:0] POS_FIFTH  = 3'd4;
  localparam logic [POS_W-1:0] POS_LAST   = 3'd5;

  // packet kinds
  localparam logic [1:0] KIND_PRIMARY  = 2'd0;
  localparam logic [1:0] KIND_EXTENDED = 2'd1;
  localparam logic [1:0] KIND_PASSTHRU = 2'd2;

  // special w values and extended codes
  localparam logic [3:0] W_EXTENDED     = 4'd2;
  localparam logic [3:0] W_PASSTHRU     = 4'd3;
  localparam logic [3:0] W_ONE_FINGER   = 4'd4;
  localparam logic [3:0] W_TWO_FINGERS  = 4'd0;
  localparam logic [3:0] CODE_SECONDARY = 4'd1;

  // finger counts
  localparam logic [1:0] FINGERS_NONE  = 2'd0;
  localparam logic [1:0] FINGERS_ONE   = 2'd1;
  localparam logic [1:0] FINGERS_TWO   = 2'd2;
  localparam logic [1:0] FINGERS_THREE = 2'd3;

  // decoded result of one packet
  typedef struct packed {
    logic [1:0]         packet_kind;
    logic [3:0]         w_value;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [7:0]         pressure;
    logic               button_down;
    logic [1:0]         finger_number;
    logic [3:0]         finger_width;
    logic [3:0]         ext_code;
    logic               second_valid;
  } result_t;

  // framed packet handed from the framer to the decoder
  typedef struct packed {
    logic                valid;
    logic [PACKET_W-1:0] data;
  } packet_t;

endpackage

// ===== src/tpfd_if.sv =====
// ----------------------------------------------------------------------------
// tpfd channel interfaces
// Byte input channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------

// touchpad byte channel
interface tpfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [tpfd_pkg::BYTE_W-1:0]   byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

// decoded packet channel
interface tpfd_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    packet_kind;
  logic [3:0]                    w_value;
  logic [tpfd_pkg::COORD_W-1:0]  pos_x;
  logic [tpfd_pkg::COORD_W-1:0]  pos_y;
  logic [7:0]                    pressure;
  logic                          button_down;
  logic [1:0]                    finger_number;
  logic [3:0]                    finger_width;
  logic [3:0]                    ext_code;
  logic                          second_valid;

  modport source (
    output valid, output packet_kind, output w_value, output pos_x, output pos_y,
    output pressure, output button_down, output finger_number, output finger_width,
    output ext_code, output second_valid, input ready
  );
  modport sink (
    input valid, input packet_kind, input w_value, input pos_x, input pos_y,
    input pressure, input button_down, input finger_number, input finger_width,
    input ext_code, input second_valid, output ready
  );
endinterface

// ===== src/tpfd_framer.sv =====
// ----------------------------------------------------------------------------
// tpfd_framer
// Checks header bytes, collects six bytes and holds the framed packet.
// ----------------------------------------------------------------------------
module tpfd_framer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_fire,
  input  logic [tpfd_pkg::BYTE_W-1:0]   byte_value,
  input  logic                          pkt_take,
  output tpfd_pkg::packet_t             pkt
);

  logic [tpfd_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [tpfd_pkg::SHIFT_W-1:0]  shift_r, shift_nxt;
  logic                          pkt_valid_r, pkt_valid_nxt;
  logic [tpfd_pkg::PACKET_W-1:0] pkt_data_r, pkt_data_nxt;
  logic [tpfd_pkg::POS_W-1:0]    pos_eff;
  logic                          hdr_bad;
  logic                          pkt_done;

  // framing decision for the incoming byte
  always_comb begin
    pos_eff = (pos_r > tpfd_pkg::POS_LAST) ? tpfd_pkg::POS_FIRST : pos_r;
    hdr_bad = 1'b0;
    if (pos_eff == tpfd_pkg::POS_FIRST) begin
      hdr_bad = (byte_value & tpfd_pkg::HDR_MASK) != tpfd_pkg::FIRST_MATCH;
    end else if (pos_eff == tpfd_pkg::POS_FOURTH) begin
      hdr_bad = (byte_value & tpfd_pkg::HDR_MASK) != tpfd_pkg::FOURTH_MATCH;
    end
    pkt_done = byte_fire && !hdr_bad && (pos_eff == tpfd_pkg::POS_LAST);
  end

  // position and byte lanes
  always_comb begin
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    if (byte_fire) begin
      if (hdr_bad || pos_eff == tpfd_pkg::POS_LAST) begin
        pos_nxt = tpfd_pkg::POS_FIRST;
      end else begin
        pos_nxt = pos_eff + 3'd1;
        case (pos_eff)
          tpfd_pkg::POS_FIRST:  shift_nxt[7:0]   = byte_value;
          tpfd_pkg::POS_SECOND: shift_nxt[15:8]  = byte_value;
          tpfd_pkg::POS_THIRD:  shift_nxt[23:16] = byte_value;
          tpfd_pkg::POS_FOURTH: shift_nxt[31:24] = byte_value;
          tpfd_pkg::POS_FIFTH:  shift_nxt[39:32] = byte_value;
          default:              shift_nxt        = shift_r;
        endcase
      end
    end
  end

  // packet holding stage
  always_comb begin
    pkt_valid_nxt = (pkt_valid_r && !pkt_take) || pkt_done;
    pkt_data_nxt  = pkt_done ? {byte_value, shift_r} : pkt_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= tpfd_pkg::POS_FIRST;
      shift_r     <= '0;
      pkt_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      shift_r     <= shift_nxt;
      pkt_valid_r <= pkt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_data_r <= pkt_data_nxt;
  end

  assign pkt.valid = pkt_valid_r;
  assign pkt.data  = pkt_data_r;

endmodule

// ===== src/tpfd_decode.sv =====
// ----------------------------------------------------------------------------
// tpfd_decode
// Splits one six-byte packet into its primary, extended or pass-through fields.
// ----------------------------------------------------------------------------
module tpfd_decode (
  input  logic [tpfd_pkg::PACKET_W-1:0] packet,
  output tpfd_pkg::result_t             result
);

  logic [3:0]                   w;
  logic [3:0]                   code;
  logic [tpfd_pkg::COORD_W-1:0] sec_x, sec_y;
  logic [7:0]                   sec_z;
  logic [tpfd_pkg::COORD_W-1:0] pri_x, pri_y;
  logic [7:0]                   pri_z;

  // field gathering
  always_comb begin
    w     = {packet[5], packet[4], packet[2], packet[26]};
    code  = packet[47:44];
    sec_x = {packet[35:32], packet[15:8], 1'b0};
    sec_y = {packet[39:36], packet[23:16], 1'b0};
    sec_z = {1'b0, packet[29:28], packet[43:40], 1'b0};
    pri_x = {packet[28], packet[11:8], packet[39:32]};
    pri_y = {packet[29], packet[15:12], packet[47:40]};
    pri_z = packet[23:16];
  end

  // selection by packet kind
  always_comb begin
    result         = '0;
    result.w_value = w;
    if (w == tpfd_pkg::W_PASSTHRU) begin
      result.packet_kind = tpfd_pkg::KIND_PASSTHRU;
    end else if (w == tpfd_pkg::W_EXTENDED) begin
      result.packet_kind = tpfd_pkg::KIND_EXTENDED;
      result.ext_code    = code;
      if (code == tpfd_pkg::CODE_SECONDARY) begin
        result.pos_x        = sec_x;
        result.pos_y        = sec_y;
        result.pressure     = sec_z;
        result.second_valid = (|sec_x) && (|sec_y) && (|sec_z);
      end
    end else begin
      result.packet_kind  = tpfd_pkg::KIND_PRIMARY;
      result.pos_x        = pri_x;
      result.pos_y        = pri_y;
      result.pressure     = pri_z;
      result.button_down  = packet[24];
      result.finger_width = (w > tpfd_pkg::W_ONE_FINGER) ? w : tpfd_pkg::W_ONE_FINGER;
      if (pri_z == 8'd0) begin
        result.finger_number = tpfd_pkg::FINGERS_NONE;
      end else if (w >= tpfd_pkg::W_ONE_FINGER) begin
        result.finger_number = tpfd_pkg::FINGERS_ONE;
      end else if (w == tpfd_pkg::W_TWO_FINGERS) begin
        result.finger_number = tpfd_pkg::FINGERS_TWO;
      end else begin
        result.finger_number = tpfd_pkg::FINGERS_THREE;
      end
    end
  end

endmodule

// ===== src/touchpad_packet_framer_decoder_core.sv =====
// ----------------------------------------------------------------------------
// touchpad_packet_framer_decoder_core
// Frames touchpad bytes into six-byte absolute packets and decodes each one.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while input ready is high. Bytes 0 and 3 are checked
// against their header patterns; a bad header drops the partial packet and
// gives no transaction. The sixth byte of a good packet lands in the packet
// register; the decoded transaction then passes into the result register, which
// drives the result channel. The packet register and the result register form
// a two-deep pipeline, so bytes keep flowing while a finished result waits to
// be taken; input ready drops only when both stages are full and the result
// side is stalled.
module touchpad_packet_framer_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  tpfd_in_if.sink    in_byte,
  tpfd_out_if.source out_result
);

  tpfd_pkg::packet_t pkt;
  tpfd_pkg::result_t dec_result;
  tpfd_pkg::result_t result_r, result_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pkt_take;
  logic              byte_fire;

  // handshake and pipeline advance
  assign pkt_take       = pkt.valid && (!out_valid_r || out_result.ready);
  assign in_byte.ready  = !pkt.valid || pkt_take;
  assign byte_fire      = in_byte.valid && in_byte.ready;

  // byte framing
  tpfd_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (byte_fire),
    .byte_value (in_byte.byte_value),
    .pkt_take   (pkt_take),
    .pkt        (pkt)
  );

  // packet decoding
  tpfd_decode u_decode (
    .packet (pkt.data),
    .result (dec_result)
  );

  // result register
  always_comb begin
    out_valid_nxt = pkt_take || (out_valid_r && !out_result.ready);
    result_nxt    = pkt_take ? dec_result : result_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  // result channel drive
  assign out_result.valid         = out_valid_r;
  assign out_result.packet_kind   = result_r.packet_kind;
  assign out_result.w_value       = result_r.w_value;
  assign out_result.pos_x         = result_r.pos_x;
  assign out_result.pos_y         = result_r.pos_y;
  assign out_result.pressure      = result_r.pressure;
  assign out_result.button_down   = result_r.button_down;
  assign out_result.finger_number = result_r.finger_number;
  assign out_result.finger_width  = result_r.finger_width;
  assign out_result.ext_code      = result_r.ext_code;
  assign out_result.second_valid  = result_r.second_valid;

endmodule
